>>> hw/rtl/assert_macros.svh
// Assertion macros used by the step generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("Same-cycle assertion failed.");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("Next-cycle assertion failed.");

`endif

>>> hw/rtl/srsg_pkg.sv
// Package with the request and response types and the codes of the step generator.
`default_nettype none

package srsg_pkg;

   localparam int unsigned POSITION_BITS  = 24;
   localparam int unsigned DELAY_BITS     = 16;

   localparam int unsigned TARGET_BITS    = POSITION_BITS;
   localparam int unsigned CSR_DATA_BITS  = DELAY_BITS;
   localparam int unsigned CSR_INDEX_BITS = 1;

   localparam int unsigned CRUISE_DELAY_RESET = 100;
   localparam int unsigned START_DELAY_RESET  = 1000;

   typedef enum logic [1:0] {
      CMD_TICK    = 2'd0,
      CMD_MOVE    = 2'd1,
      CMD_SET_POS = 2'd2
   } command_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_CRUISE_DELAY = 1'b0,
      CSR_START_DELAY  = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic [1:0]                    command;
      logic signed [TARGET_BITS-1:0] target_position;
   } req_type;

   typedef struct packed {
      logic step_pulse;
      logic direction;
      logic motor_enable;
      logic busy_res;
   } rsp_type;

endpackage

`default_nettype wire

>>> hw/rtl/stepper_ramp_step_generator.sv
// Top level of the stepper step generator with a linear-delay trapezoidal ramp.
//
// The block takes one request in every cycle unless a response waits untaken,
// and returns exactly one response per request, in the cycle after acceptance,
// through a single response register; a new request is taken while the previous
// response waits as long as the response side takes it in the same cycle. A tick
// request advances the move by one time unit, a move request loads a new profile
// and a set-position request loads the position. This rate is set by the single
// pass of logic from the request port and the motion state into that register.
// The user must write delay registers through the csr_ port only while the block
// is idle; the block does not enforce it. There is no clearing pass after reset.
`default_nettype none

module stepper_ramp_step_generator (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  req_valid,
   output      logic                                  req_ready,
   input  wire srsg_pkg::req_type                     req_payload,
   output      logic                                  rsp_valid,
   input  wire logic                                  rsp_ready,
   output      srsg_pkg::rsp_type                     rsp_payload,
   input  wire logic                                  csr_we,
   input  wire logic [srsg_pkg::CSR_INDEX_BITS-1:0]   csr_index,
   input  wire logic [srsg_pkg::CSR_DATA_BITS-1:0]    csr_data
);

   import srsg_pkg::*;

   localparam int unsigned CMP_BITS = (POSITION_BITS > DELAY_BITS) ? POSITION_BITS : DELAY_BITS;

   logic [DELAY_BITS-1:0]    cruise_delay_ff;
   logic [DELAY_BITS-1:0]    start_delay_ff;

   logic [POSITION_BITS-1:0] position_ff, position_in;
   logic [POSITION_BITS-1:0] total_steps_ff, total_steps_in;
   logic [POSITION_BITS-1:0] steps_done_ff, steps_done_in;
   logic [POSITION_BITS-1:0] ramp_steps_ff, ramp_steps_in;
   logic [POSITION_BITS-1:0] decel_start_ff, decel_start_in;
   logic [DELAY_BITS-1:0]    current_delay_ff, current_delay_in;
   logic [DELAY_BITS-1:0]    elapsed_ticks_ff, elapsed_ticks_in;
   logic                     moving_ff, moving_in;
   logic                     dir_flag_ff, dir_flag_in;
   logic                     enable_flag_ff, enable_flag_in;

   logic                     rsp_valid_ff;
   rsp_type                  rsp_ff, rsp_in;

   logic                     req_fire;

   logic signed [POSITION_BITS-1:0] target;
   logic signed [POSITION_BITS:0]   delta;
   logic [POSITION_BITS:0]          delta_abs;
   logic [POSITION_BITS-1:0]        mag;
   logic [DELAY_BITS-1:0]           ramp_raw;
   logic [CMP_BITS-1:0]             ramp_wide;
   logic [CMP_BITS-1:0]             half_wide;
   logic [POSITION_BITS-1:0]        ramp_clamped;
   logic [DELAY_BITS-1:0]           elapsed_inc;
   logic [DELAY_BITS-1:0]           delay_dec;
   logic [DELAY_BITS-1:0]           delay_adj;
   logic [POSITION_BITS-1:0]        steps_next;
   logic                            fire;

   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Move profile, tick arithmetic, position load and response fields.
   always_comb begin
      target    = POSITION_BITS'(req_payload.target_position);
      delta     = (POSITION_BITS + 1)'(target) - (POSITION_BITS + 1)'(signed'(position_ff));
      delta_abs = delta[POSITION_BITS] ? (POSITION_BITS + 1)'(-delta) : delta;
      mag       = delta_abs[POSITION_BITS-1:0];
      ramp_raw  = (start_delay_ff > cruise_delay_ff) ? (start_delay_ff - cruise_delay_ff) : '0;
      ramp_wide = CMP_BITS'(ramp_raw);
      half_wide = CMP_BITS'(mag >> 1);
      ramp_clamped = (ramp_wide > half_wide) ? POSITION_BITS'(half_wide)
                                             : POSITION_BITS'(ramp_wide);

      elapsed_inc = (elapsed_ticks_ff != '1) ? (elapsed_ticks_ff + 1'b1) : elapsed_ticks_ff;
      fire        = moving_ff && (elapsed_inc >= current_delay_ff);
      delay_dec   = ((steps_done_ff < ramp_steps_ff) && (current_delay_ff > DELAY_BITS'(1)))
                    ? (current_delay_ff - 1'b1) : current_delay_ff;
      delay_adj   = ((steps_done_ff >= decel_start_ff) && (delay_dec != '1))
                    ? (delay_dec + 1'b1) : delay_dec;
      steps_next  = steps_done_ff + 1'b1;

      position_in      = position_ff;
      total_steps_in   = total_steps_ff;
      steps_done_in    = steps_done_ff;
      ramp_steps_in    = ramp_steps_ff;
      decel_start_in   = decel_start_ff;
      current_delay_in = current_delay_ff;
      elapsed_ticks_in = elapsed_ticks_ff;
      moving_in        = moving_ff;
      dir_flag_in      = dir_flag_ff;
      enable_flag_in   = enable_flag_ff;

      case (req_payload.command)
         CMD_TICK: begin
            if (moving_ff) begin
               if (fire) begin
                  elapsed_ticks_in = '0;
                  current_delay_in = delay_adj;
                  steps_done_in    = steps_next;
                  if (steps_next >= total_steps_ff) begin
                     moving_in      = 1'b0;
                     enable_flag_in = 1'b0;
                  end
               end else begin
                  elapsed_ticks_in = elapsed_inc;
               end
            end
         end
         CMD_MOVE: begin
            total_steps_in   = mag;
            dir_flag_in      = !delta[POSITION_BITS] && (delta != '0);
            ramp_steps_in    = ramp_clamped;
            decel_start_in   = mag - ramp_clamped;
            steps_done_in    = '0;
            elapsed_ticks_in = '0;
            current_delay_in = start_delay_ff;
            moving_in        = (mag != '0);
            if (mag != '0) begin
               enable_flag_in = 1'b1;
            end
            position_in      = target;
         end
         CMD_SET_POS: begin
            position_in = target;
         end
         default: begin
         end
      endcase

      rsp_in.step_pulse   = (req_payload.command == CMD_TICK) && fire;
      rsp_in.direction    = dir_flag_in;
      rsp_in.motor_enable = enable_flag_in;
      rsp_in.busy_res     = moving_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cruise_delay_ff <= DELAY_BITS'(CRUISE_DELAY_RESET);
         start_delay_ff  <= DELAY_BITS'(START_DELAY_RESET);
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CRUISE_DELAY: cruise_delay_ff <= DELAY_BITS'(csr_data);
            CSR_START_DELAY:  start_delay_ff  <= DELAY_BITS'(csr_data);
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff      <= '0;
         total_steps_ff   <= '0;
         steps_done_ff    <= '0;
         ramp_steps_ff    <= '0;
         decel_start_ff   <= '0;
         current_delay_ff <= '0;
         elapsed_ticks_ff <= '0;
         moving_ff        <= 1'b0;
         dir_flag_ff      <= 1'b0;
         enable_flag_ff   <= 1'b0;
      end else if (req_fire) begin
         position_ff      <= position_in;
         total_steps_ff   <= total_steps_in;
         steps_done_ff    <= steps_done_in;
         ramp_steps_ff    <= ramp_steps_in;
         decel_start_ff   <= decel_start_in;
         current_delay_ff <= current_delay_in;
         elapsed_ticks_ff <= elapsed_ticks_in;
         moving_ff        <= moving_in;
         dir_flag_ff      <= dir_flag_in;
         enable_flag_ff   <= enable_flag_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_ff <= rsp_in;
      end
   end

`include "assert_macros.svh"

   `ASSERT_SAME_CYCLE(a_moving_enabled, clock, reset, moving_ff, enable_flag_ff)
   `ASSERT_SAME_CYCLE(a_steps_below_total, clock, reset, moving_ff, steps_done_ff < total_steps_ff)
   `ASSERT_SAME_CYCLE(a_ramp_before_decel, clock, reset, 1'b1, ramp_steps_ff <= decel_start_ff)
   `ASSERT_NEXT_CYCLE(a_pulse_when_moving, clock, reset, req_fire && fire, rsp_valid_ff)

endmodule

`default_nettype wire

>>> bench/tb_stepper_ramp_step_generator.sv
// Self-checking testbench for the stepper step generator with a trapezoidal ramp.
`timescale 1ns / 1ps

module tb_stepper_ramp_step_generator;
   import srsg_pkg::*;

   localparam logic [1:0] CMD_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   wire req_ready;
   req_type req_payload = '0;
   wire rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_type rsp_payload;
   logic csr_we = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0] csr_data = '0;

   stepper_ramp_step_generator uut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   // Predicted motion state and delay settings.
   logic [15:0] cruise_ticks = 16'(CRUISE_DELAY_RESET);
   logic [15:0] start_ticks = 16'(START_DELAY_RESET);
   logic signed [23:0] motor_position = '0;
   logic [23:0] move_length = '0;
   logic [23:0] steps_taken = '0;
   logic [23:0] accel_steps = '0;
   logic [23:0] decel_from = '0;
   logic [15:0] pace_ticks = '0;
   logic [15:0] ticks_since_step = '0;
   logic in_motion = 1'b0;
   logic heading_up = 1'b0;
   logic driver_on = 1'b0;

   req_type req_backlog[$];
   rsp_type pending_status[$];
   logic signed [23:0] plan_pos = '0;
   int unsigned issued_cnt = 0;
   int unsigned accepted_cnt = 0;
   int unsigned mismatches = 0;
   int unsigned pulses_seen = 0;
   int unsigned settings_cnt = 1;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   logic rsp_hold = 1'b0;

   function automatic rsp_type advance_motion(req_type rq);
      rsp_type res;
      logic signed [24:0] delta;
      logic [23:0] span;
      logic [23:0] ramp_len;
      logic stepped;
      stepped = 1'b0;
      case (rq.command)
         CMD_TICK: begin
            if (in_motion) begin
               if (ticks_since_step != 16'hFFFF)
                  ticks_since_step++;
               if (ticks_since_step >= pace_ticks) begin
                  ticks_since_step = '0;
                  if (steps_taken < accel_steps && pace_ticks > 16'd1)
                     pace_ticks--;
                  if (steps_taken >= decel_from && pace_ticks != 16'hFFFF)
                     pace_ticks++;
                  steps_taken++;
                  if (steps_taken >= move_length) begin
                     in_motion = 1'b0;
                     driver_on = 1'b0;
                  end
                  stepped = 1'b1;
               end
            end
         end
         CMD_MOVE: begin
            delta = $signed({rq.target_position[23], rq.target_position})
                  - $signed({motor_position[23], motor_position});
            span = (delta < 0) ? 24'(-delta) : 24'(delta);
            ramp_len = (start_ticks > cruise_ticks) ? 24'(start_ticks - cruise_ticks) : '0;
            if (ramp_len > span / 2)
               ramp_len = span / 2;
            move_length = span;
            heading_up = (delta > 0);
            accel_steps = ramp_len;
            decel_from = span - ramp_len;
            steps_taken = '0;
            ticks_since_step = '0;
            pace_ticks = start_ticks;
            in_motion = (span != 0);
            if (in_motion)
               driver_on = 1'b1;
            motor_position = rq.target_position;
         end
         CMD_SET_POS: motor_position = rq.target_position;
         default: ;
      endcase
      res.step_pulse = stepped;
      res.direction = heading_up;
      res.motor_enable = driver_on;
      res.busy_res = in_motion;
      return res;
   endfunction

   function automatic void queue_request(logic [1:0] cmd, logic signed [23:0] tgt);
      req_type rq;
      rq.command = cmd;
      rq.target_position = tgt;
      req_backlog.push_back(rq);
      if (cmd == CMD_MOVE || cmd == CMD_SET_POS)
         plan_pos = tgt;
   endfunction

   // Mostly ticks with short moves around the current position, so that moves
   // run to completion; long moves, position loads and unused codes are mixed in.
   task automatic queue_random(int unsigned count);
      int unsigned pick;
      int offset;
      repeat (count) begin
         pick = $urandom_range(99);
         offset = int'($urandom_range(24)) - 12;
         if (pick < 82)
            queue_request(CMD_TICK, 24'($urandom));
         else if (pick < 89)
            queue_request(CMD_MOVE, plan_pos + 24'(offset));
         else if (pick < 92)
            queue_request(CMD_SET_POS, 24'($urandom));
         else if (pick < 95)
            queue_request(CMD_MOVE, 24'($urandom));
         else
            queue_request(CMD_UNUSED, 24'($urandom));
      end
   endtask

   task automatic wait_idle();
      while (req_backlog.size() != 0 || issued_cnt != accepted_cnt || pending_status.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic write_csr(csr_index_type idx, logic [15:0] value);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic run_phase(logic [15:0] cruise, logic [15:0] start, int unsigned send_pct,
                            int unsigned recv_pct, int unsigned count);
      wait_idle();
      write_csr(CSR_CRUISE_DELAY, cruise);
      write_csr(CSR_START_DELAY, start);
      settings_cnt++;
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      queue_random(count);
   endtask

   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (issued_cnt == accepted_cnt) begin
         if (req_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid <= 1'b1;
            req_payload <= req_backlog.pop_front();
            issued_cnt++;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(negedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= !rsp_hold && ($urandom_range(99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : monitor
      rsp_type want;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               CSR_CRUISE_DELAY: cruise_ticks = csr_data;
               CSR_START_DELAY: start_ticks = csr_data;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (rsp_payload.step_pulse === 1'b1)
               pulses_seen++;
            if (pending_status.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Response with no request outstanding: %b", rsp_payload);
            end else begin
               want = pending_status.pop_front();
               if (rsp_payload.step_pulse !== want.step_pulse
                   || rsp_payload.direction !== want.direction
                   || rsp_payload.motor_enable !== want.motor_enable
                   || rsp_payload.busy_res !== want.busy_res) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("Mismatch: expected step=%b dir=%b en=%b busy=%b, %s%b %b %b %b",
                              want.step_pulse, want.direction, want.motor_enable,
                              want.busy_res, "got ", rsp_payload.step_pulse,
                              rsp_payload.direction, rsp_payload.motor_enable,
                              rsp_payload.busy_res);
               end
            end
         end
         if (req_valid && req_ready) begin
            pending_status.push_back(advance_motion(req_payload));
            accepted_cnt++;
         end
      end
   end

   // Long hold-off on the response side so that the block backs up into its input.
   initial begin
      while (accepted_cnt < 200)
         @(posedge clock);
      rsp_hold = 1'b1;
      repeat (300) @(posedge clock);
      rsp_hold = 1'b0;
   end

   initial begin
      #1_000_000;
      $display("Run timed out.");
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      send_idle_pct = 29;
      recv_idle_pct = 68;

      queue_request(CMD_TICK, 24'h000000);
      queue_request(CMD_UNUSED, 24'h7FFFFF);
      queue_request(CMD_SET_POS, 24'h800000);
      queue_request(CMD_MOVE, 24'h800000);
      queue_request(CMD_SET_POS, 24'h7FFFFF);
      queue_request(CMD_MOVE, 24'h800000);
      queue_request(CMD_TICK, 24'hFFFFFF);
      queue_request(CMD_MOVE, 24'h7FFFFF);
      queue_request(CMD_SET_POS, 24'h000000);
      queue_request(CMD_TICK, 24'h555555);
      queue_request(CMD_TICK, 24'hAAAAAA);
      queue_request(CMD_UNUSED, 24'h555555);
      queue_request(CMD_TICK, 24'h000000);
      queue_request(CMD_MOVE, 24'h000000);
      queue_request(CMD_TICK, 24'h000000);
      queue_request(CMD_UNUSED, 24'hAAAAAA);
      queue_request(CMD_SET_POS, 24'h2AAAAA);
      queue_request(CMD_MOVE, 24'h2AAAAD);
      queue_request(CMD_TICK, 24'h000000);
      queue_request(CMD_SET_POS, 24'hFFFFFF);
      queue_request(CMD_TICK, 24'h000000);
      queue_request(CMD_MOVE, 24'hFFFFF0);
      queue_request(CMD_TICK, 24'h000000);

      run_phase(16'd2, 16'd6, 29, 68, 300);
      run_phase(16'd1, 16'd1, 29, 68, 250);
      run_phase(16'd7, 16'd3, 68, 29, 250);
      run_phase(16'd65535, 16'd65535, 68, 29, 100);
      run_phase(16'd1, 16'd65535, 0, 0, 100);
      run_phase(16'd3, 16'd10, 0, 0, 500);

      wait_idle();
      repeat (16) @(negedge clock);
      $display("Checked %0d requests under %0d delay settings, %0d step pulses observed.",
               accepted_cnt, settings_cnt, pulses_seen);
      $display("Mismatches: %0d, responses still outstanding: %0d.",
               mismatches, pending_status.size());
      if (mismatches == 0 && pending_status.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule

>>> sim.f
+incdir+hw/rtl
hw/rtl/srsg_pkg.sv
hw/rtl/stepper_ramp_step_generator.sv
bench/tb_stepper_ramp_step_generator.sv
